>>> rtl/a2w_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the wheel rpm block.
// No dependencies; every other file uses this package.
package a2w_pkg;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int FUNC_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam int DIV_DVD_W = 64;
  localparam int DIV_DVS_W = 32;
  localparam int DIV_CNT_W = 7;
  localparam int CORDIC_W  = 33;

  localparam logic [30:0] PI_HALF_Q30        = 31'd1686629713;
  localparam logic [23:0] THIRTY_OVER_PI_Q20 = 24'd10013163;
  localparam logic signed [61:0] VEL_SAT_Q16 = 62'sh80_0000_0000;

  typedef logic [FUNC_W-1:0] func_t;
  localparam func_t FUNC_DRIVE = 2'd0;
  localparam func_t FUNC_GEAR  = 2'd1;
  localparam func_t FUNC_ESTOP = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_VEL_LIMIT = 2'd0;
  localparam cfg_idx_t CFG_BASE      = 2'd1;
  localparam cfg_idx_t CFG_TREAD     = 2'd2;
  localparam cfg_idx_t CFG_RADIUS    = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_CORDIC, S_TAN_GO, S_TAN_WAIT, S_TAN_FIX, S_MUL_OFF,
    S_OFF_GO, S_OFF_WAIT, S_OFF_FIX, S_VEL, S_MUL_LO, S_MUL_HI,
    S_RPM_GO, S_RPM_WAIT, S_RPM_FIX, S_EMIT
  } state_t;

  typedef struct packed {
    logic                   start;
    logic [DIV_CNT_W-1:0]   nbits;
    logic [DIV_DVD_W-1:0]   dividend;
    logic [DIV_DVS_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_DVD_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic                       start;
    logic signed [CORDIC_W-1:0] z0;
  } cordic_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
  } cordic_rsp_t;

  // atan(2^-i) in Q30, rounded down
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] val;
    case (idx)
      5'd0:  val = 30'd843314856;
      5'd1:  val = 30'd497837829;
      5'd2:  val = 30'd263043836;
      5'd3:  val = 30'd133525158;
      5'd4:  val = 30'd67021686;
      5'd5:  val = 30'd33543515;
      5'd6:  val = 30'd16775850;
      5'd7:  val = 30'd8388437;
      5'd8:  val = 30'd4194282;
      5'd9:  val = 30'd2097149;
      5'd10: val = 30'd1048575;
      5'd11: val = 30'd524287;
      5'd12: val = 30'd262143;
      5'd13: val = 30'd131071;
      5'd14: val = 30'd65535;
      5'd15: val = 30'd32767;
      5'd16: val = 30'd16383;
      5'd17: val = 30'd8191;
      5'd18: val = 30'd4095;
      5'd19: val = 30'd2047;
      5'd20: val = 30'd1023;
      5'd21: val = 30'd511;
      5'd22: val = 30'd255;
      5'd23: val = 30'd127;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> rtl/a2w_divider.sv
`timescale 1ns / 1ps
// Shared restoring divider: unsigned, one quotient bit per cycle.
// Depends on a2w_pkg for the request and response structs.
module a2w_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  a2w_pkg::div_req_t req,
  output a2w_pkg::div_rsp_t rsp
);
  import a2w_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [DIV_DVD_W-1:0]  dvd_r;
  logic [DIV_DVS_W-1:0]  dvs_r;
  logic [DIV_DVS_W-1:0]  rem_r;
  logic [DIV_DVD_W-1:0]  quot_r;

  logic [5:0]            bit_idx;
  logic [DIV_DVS_W:0]    trial;
  logic                  q_bit;
  logic [DIV_DVS_W-1:0]  rem_nxt;

  always_comb begin
    bit_idx = 6'(cnt_r - 7'd1);
    trial   = {rem_r, dvd_r[bit_idx]};
    q_bit   = trial >= {1'b0, dvs_r};
    rem_nxt = q_bit ? DIV_DVS_W'(trial - {1'b0, dvs_r}) : trial[DIV_DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r  <= req.dividend;
      dvs_r  <= req.divisor;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[DIV_DVD_W-2:0], q_bit};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

>>> rtl/a2w_cordic.sv
`timescale 1ns / 1ps
// Iterative rotation CORDIC: one micro-rotation per cycle, floor shifts.
// Depends on a2w_pkg for the atan table and the request/response structs.
module a2w_cordic #(
  parameter int ITER = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  a2w_pkg::cordic_req_t req,
  output a2w_pkg::cordic_rsp_t rsp
);
  import a2w_pkg::*;

  localparam int CNT_W = $clog2(ITER);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ITER - 1);

  logic                       busy_r;
  logic                       done_r;
  logic [CNT_W-1:0]           i_r;
  logic signed [CORDIC_W-1:0] x_r;
  logic signed [CORDIC_W-1:0] y_r;
  logic signed [CORDIC_W-1:0] z_r;

  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;
  logic signed [CORDIC_W-1:0] ang;

  always_comb begin
    dx  = y_r >>> i_r;
    dy  = x_r >>> i_r;
    ang = $signed({3'b000, atan_q30(5'(i_r))});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
      end else if (busy_r) begin
        i_r <= i_r + 1'b1;
        if (i_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r <= CORDIC_W'(34'sd1 <<< 30);
      y_r <= '0;
      z_r <= req.z0;
    end else if (busy_r) begin
      // non-negative residual angle rotates counterclockwise
      if (!z_r[CORDIC_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - ang;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + ang;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.x    = x_r;
  assign rsp.y    = y_r;

endmodule

>>> rtl/ackermann_to_wheel_rpm_top.sv
`timescale 1ns / 1ps
// Speed/steer command to left/right wheel rpm converter, top level.
// Depends on a2w_pkg, a2w_cordic and a2w_divider.
//
// Usage:
//   Input requests arrive on in_* (tuser = item kind). A drive request turns
//   speed and steering angle into left/right wheel rpm; gear and emergency
//   requests update stored flags. Every request yields exactly one result on
//   out_*, carrying the held wheel rpm values and status flags.
//   User writes registers via cfg_we/cfg_index/cfg_wdata only while idle (unchecked).
// Timing:
//   One request at a time; in_tready is high only while idle.
//   Gear, emergency, ignored and stopped drive requests go from idle to emit.
//   For a computed drive request the CORDIC runs TAN_ITERATIONS steps, then the
//   single shared divider runs 49 steps for the tangent, 62 for the yaw offset
//   and 28 per wheel.
// Reset:
//   rst_n is synchronous; clears flags, held rpm, the output valid flag and
//   restores the register defaults (830, 1000, 500, 100).
// Stall:
//   The result sits in the output register until out_tready; the block takes
//   the next request as soon as the result is loaded there.
module ackermann_to_wheel_rpm_top #(
  parameter int ANGLE_FRAC_BITS = 14,
  parameter int TAN_ITERATIONS  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // speed_mm_s[15:0], steer_angle[31:16], gear_is_park[32], emergency_flag[33]
  input  logic [a2w_pkg::IN_DATA_W-1:0]  in_tdata,
  // func[1:0]
  input  logic [a2w_pkg::FUNC_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // command_taken[0], left_rpm[16:1], right_rpm[32:17], drive_enable[33],
  // speed_was_clamped[34]
  output logic [a2w_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_we,
  input  logic [a2w_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [a2w_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import a2w_pkg::*;

  localparam int ANG_SHIFT = 30 - ANGLE_FRAC_BITS;
  localparam logic signed [CORDIC_W-1:0] ANGLE_MAX =
    $signed(CORDIC_W'(PI_HALF_Q30 >> ANG_SHIFT));

  // configuration
  logic [14:0] vlim_r;
  logic [12:0] base_r;
  logic [12:0] tread_r;
  logic [10:0] radius_r;

  // item state
  logic              gear_seen_r;
  logic              park_r;
  logic              estop_r;
  logic signed [15:0] left_held_r;
  logic signed [15:0] right_held_r;

  // latched request
  func_t             func_r;
  logic              park_in_r;
  logic              estop_in_r;
  logic signed [15:0] v_r;
  logic signed [15:0] a_r;
  logic              clamped_r;

  // datapath
  logic signed [29:0] vt_r;
  logic signed [32:0] tan_r;
  logic signed [62:0] prod_r;
  logic signed [60:0] off_r;
  logic [39:0]        mag_r;
  logic               neg_r;
  logic [63:0]        acc_r;
  logic               sel_r;
  logic signed [15:0] left_new_r;
  logic signed [15:0] right_new_r;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  state_t state_r, state_nxt;

  div_req_t    div_req;
  div_rsp_t    div_rsp;
  cordic_req_t cor_req;
  cordic_rsp_t cor_rsp;

  logic              in_fire;
  logic              out_free;
  logic              emit_fire;
  logic              in_compute;
  logic signed [15:0] v_in;
  logic              v_over;
  logic [12:0]       base_eff;
  logic [10:0]       rad_eff;

  logic signed [CORDIC_W-1:0] a_ext;
  logic signed [CORDIC_W-1:0] a_sat;
  logic [CORDIC_W-1:0]        y_mag;
  logic [32:0]                tan_mag;
  logic [62:0]                prod_mag;
  logic signed [31:0]         mid;
  logic signed [61:0]         vel;
  logic [19:0]                mul_a;
  logic [43:0]                pp;
  logic [63:0]                rpm_sum;
  logic [DIV_DVD_W-1:0]       q;
  logic signed [15:0]         rpm_val;

  logic              taken;
  logic              stop;
  logic signed [15:0] left_nxt;
  logic signed [15:0] right_nxt;

  a2w_cordic #(.ITER(TAN_ITERATIONS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cor_req),
    .rsp   (cor_rsp)
  );

  a2w_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------- input side ----------------
  always_comb begin
    v_in       = $signed(in_tdata[15:0]);
    v_over     = 17'(v_in) > $signed({2'b00, vlim_r});
    in_compute = (in_tuser == FUNC_DRIVE) && gear_seen_r && !park_r && !estop_r;
    in_fire    = in_tvalid && in_tready;
    out_free   = !out_valid_r || out_tready;
    base_eff   = (base_r == '0) ? 13'd1 : base_r;
    rad_eff    = (radius_r == '0) ? 11'd1 : radius_r;
  end

  // ---------------- state machine ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_tvalid) state_nxt = in_compute ? S_PREP : S_EMIT;
      S_PREP:     state_nxt = S_CORDIC;
      S_CORDIC:   if (cor_rsp.done) state_nxt = S_TAN_GO;
      S_TAN_GO:   state_nxt = S_TAN_WAIT;
      S_TAN_WAIT: if (div_rsp.done) state_nxt = S_TAN_FIX;
      S_TAN_FIX:  state_nxt = S_MUL_OFF;
      S_MUL_OFF:  state_nxt = S_OFF_GO;
      S_OFF_GO:   state_nxt = S_OFF_WAIT;
      S_OFF_WAIT: if (div_rsp.done) state_nxt = S_OFF_FIX;
      S_OFF_FIX:  state_nxt = S_VEL;
      S_VEL:      state_nxt = S_MUL_LO;
      S_MUL_LO:   state_nxt = S_MUL_HI;
      S_MUL_HI:   state_nxt = S_RPM_GO;
      S_RPM_GO:   state_nxt = S_RPM_WAIT;
      S_RPM_WAIT: if (div_rsp.done) state_nxt = S_RPM_FIX;
      S_RPM_FIX:  state_nxt = sel_r ? S_EMIT : S_VEL;
      S_EMIT:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- datapath combinational ----------------
  always_comb begin
    a_ext = CORDIC_W'(a_r);
    if (a_ext > ANGLE_MAX) begin
      a_sat = ANGLE_MAX;
    end else if (a_ext < -ANGLE_MAX) begin
      a_sat = -ANGLE_MAX;
    end else begin
      a_sat = a_ext;
    end

    y_mag    = cor_rsp.y[CORDIC_W-1] ? CORDIC_W'(-cor_rsp.y) : CORDIC_W'(cor_rsp.y);
    q        = div_rsp.quot;
    tan_mag  = (q > 64'h8000_0000) ? 33'h0_8000_0000 : q[32:0];
    prod_mag = prod_r[62] ? 63'(-prod_r) : 63'(prod_r);
    mid      = $signed({v_r, 16'h0000});
    vel      = sel_r ? (62'(mid) + 62'(off_r)) : (62'(mid) - 62'(off_r));
    mul_a    = (state_r == S_MUL_HI) ? mag_r[39:20] : mag_r[19:0];
    pp       = {24'h00_0000, mul_a} * {20'h0_0000, THIRTY_OVER_PI_Q20};
    // round half away from zero: add half the divisor before the shift
    rpm_sum  = acc_r + {18'h0_0000, rad_eff, 35'h0};

    if (neg_r) begin
      rpm_val = (q > 64'd32768) ? 16'sh8000 : 16'(-$signed(q[16:0]));
    end else begin
      rpm_val = (q > 64'd32767) ? 16'sh7FFF : $signed(q[15:0]);
    end
  end

  // ---------------- sequencer outputs ----------------
  always_comb begin
    in_tready        = (state_r == S_IDLE);
    emit_fire        = (state_r == S_EMIT) && out_free;
    cor_req.start    = (state_r == S_PREP);
    cor_req.z0       = a_sat <<< ANG_SHIFT;
    div_req.start    = 1'b0;
    div_req.nbits    = '0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_r)
      S_TAN_GO: begin
        div_req.start    = 1'b1;
        div_req.nbits    = 7'd49;
        div_req.dividend = {15'h0000, y_mag, 16'h0000};
        div_req.divisor  = (cor_rsp.x <= 0) ? 32'd1 : cor_rsp.x[31:0];
      end
      S_OFF_GO: begin
        div_req.start    = 1'b1;
        div_req.nbits    = 7'd62;
        div_req.dividend = 64'(prod_mag) + 64'(base_eff);
        div_req.divisor  = 32'({base_eff, 1'b0});
      end
      S_RPM_GO: begin
        div_req.start    = 1'b1;
        div_req.nbits    = 7'd28;
        div_req.dividend = {36'h0, rpm_sum[63:36]};
        div_req.divisor  = 32'(rad_eff);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r     <= in_tuser;
      park_in_r  <= in_tdata[32];
      estop_in_r <= in_tdata[33];
      v_r        <= v_over ? $signed({1'b0, vlim_r}) : v_in;
      clamped_r  <= v_over;
      a_r        <= $signed(in_tdata[31:16]);
      sel_r      <= 1'b0;
    end
    case (state_r)
      S_PREP:    vt_r <= 30'(v_r) * 30'($signed({1'b0, tread_r}));
      S_TAN_FIX: tan_r <= cor_rsp.y[CORDIC_W-1] ? -$signed(tan_mag) : $signed(tan_mag);
      S_MUL_OFF: prod_r <= 63'(vt_r) * 63'(tan_r);
      S_OFF_FIX: begin
        off_r <= prod_r[62] ? -$signed({1'b0, q[59:0]}) : $signed({1'b0, q[59:0]});
      end
      S_VEL: begin
        if (vel > VEL_SAT_Q16) begin
          mag_r <= 40'h80_0000_0000;
          neg_r <= 1'b0;
        end else if (vel < -VEL_SAT_Q16) begin
          mag_r <= 40'h80_0000_0000;
          neg_r <= 1'b1;
        end else begin
          mag_r <= vel[61] ? 40'(-vel) : 40'(vel);
          neg_r <= vel[61];
        end
      end
      S_MUL_LO:  acc_r <= {20'h0_0000, pp};
      S_MUL_HI:  acc_r <= acc_r + {pp, 20'h0_0000};
      S_RPM_FIX: begin
        if (sel_r) begin
          right_new_r <= rpm_val;
        end else begin
          left_new_r <= rpm_val;
          sel_r      <= 1'b1;
        end
      end
      default: begin
        // hold
      end
    endcase
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlim_r   <= 15'd830;
      base_r   <= 13'd1000;
      tread_r  <= 13'd500;
      radius_r <= 11'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VEL_LIMIT: vlim_r   <= cfg_wdata[14:0];
        CFG_BASE:      base_r   <= cfg_wdata[12:0];
        CFG_TREAD:     tread_r  <= cfg_wdata[12:0];
        CFG_RADIUS:    radius_r <= cfg_wdata[10:0];
        default:       vlim_r   <= vlim_r;
      endcase
    end
  end

  // ---------------- state update and result ----------------
  always_comb begin
    taken     = (func_r == FUNC_DRIVE) && gear_seen_r;
    stop      = park_r || estop_r;
    left_nxt  = left_held_r;
    right_nxt = right_held_r;
    if (taken) begin
      left_nxt  = stop ? 16'sd0 : left_new_r;
      right_nxt = stop ? 16'sd0 : right_new_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gear_seen_r  <= 1'b0;
      park_r       <= 1'b0;
      estop_r      <= 1'b0;
      left_held_r  <= '0;
      right_held_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (emit_fire) begin
        if (func_r == FUNC_GEAR) begin
          gear_seen_r <= 1'b1;
          park_r      <= park_in_r;
        end
        if (func_r == FUNC_ESTOP) begin
          estop_r <= estop_in_r;
        end
        left_held_r  <= left_nxt;
        right_held_r <= right_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data_r <= {5'b00000, taken && clamped_r,
                     (left_nxt != 16'sd0) || (right_nxt != 16'sd0),
                     right_nxt, left_nxt, taken};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> rtl/a2w_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the wheel rpm block, bound to the top level.
// Depends on a2w_pkg for port widths.
module a2w_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [a2w_pkg::OUT_DATA_W-1:0] out_tdata
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request in flight: ready drops right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

  // drive enable follows the reported wheel speeds
  a_drive_en: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[33] == ((out_tdata[16:1] != 16'h0000) ||
                                     (out_tdata[32:17] != 16'h0000)))
    else $error("drive enable disagrees with wheel speeds");

  // clamp flag only on a taken command
  a_clamp_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> !out_tdata[34])
    else $error("clamp flag on an untaken request");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind ackermann_to_wheel_rpm_top a2w_checker u_a2w_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for ackermann_to_wheel_rpm_top: random and directed requests,
// register settings, stalls on both streams. Depends on a2w_pkg and the RTL top level.
module tb_top;
  import a2w_pkg::*;

  localparam func_t FUNC_UNUSED = 2'd3;
  localparam int    TAN_STEPS   = 16;

  typedef struct packed {
    func_t              func;
    logic               estop;
    logic               park;
    logic signed [15:0] angle;
    logic signed [15:0] speed;
  } request_t;

  // Field order matches out_tdata from bit 34 down to bit 0.
  typedef struct packed {
    logic               clamped;
    logic               enable;
    logic signed [15:0] right;
    logic signed [15:0] left;
    logic               taken;
  } wheel_result_t;

  localparam int RESULT_W = $bits(wheel_result_t);

  class wheel_rpm_scoreboard;
    logic [14:0]        vel_limit;
    logic [12:0]        wheel_base;
    logic [12:0]        wheel_tread;
    logic [10:0]        wheel_radius;
    bit                 gear_seen;
    bit                 park_on;
    bit                 estop_on;
    logic signed [15:0] left_held;
    logic signed [15:0] right_held;
    longint             atan_steps[TAN_STEPS];
    wheel_result_t      expected_q[$];
    int n_requests, n_results, n_errors;
    int n_computed, n_stopped, n_ignored, n_clamped, n_saturated;

    function new();
      vel_limit    = 15'd830;
      wheel_base   = 13'd1000;
      wheel_tread  = 13'd500;
      wheel_radius = 11'd100;
      left_held    = '0;
      right_held   = '0;
      atan_steps = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                     16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                     262143, 131071, 65535, 32767};
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_VEL_LIMIT: vel_limit    = val[14:0];
        CFG_BASE:      wheel_base   = val[12:0];
        CFG_TREAD:     wheel_tread  = val[12:0];
        CFG_RADIUS:    wheel_radius = val[10:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Divide with the quotient rounded half away from zero; den is positive.
    function longint round_div(longint num, longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
    endfunction

    function longint tan_q16(logic signed [15:0] ang);
      longint amax, x, y, z, dx, dy, t, a;
      amax = longint'(PI_HALF_Q30) >>> 16;
      a = ang;
      x = 64'sd1 <<< 30;
      y = 0;
      z = clip(a, -amax, amax) * 65536;
      for (int i = 0; i < TAN_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= atan_steps[i];
        end else begin
          x += dx;
          y -= dy;
          z += atan_steps[i];
        end
      end
      if (x < 1) x = 1;
      t = (y * 65536) / x;
      return clip(t, -(64'sd1 <<< 31), 64'sd1 <<< 31);
    endfunction

    function logic signed [15:0] wheel_rpm(longint vel_q16, longint radius);
      longint v, r;
      v = clip(vel_q16, -(64'sd1 <<< 39), 64'sd1 <<< 39);
      r = round_div(v * longint'(THIRTY_OVER_PI_Q20), radius <<< 36);
      return 16'(clip(r, -32768, 32767));
    endfunction

    function void note_request(request_t r);
      wheel_result_t res;
      longint v, lim, base, tread, rad, off, mid;
      res = '0;
      n_requests++;
      case (r.func)
        FUNC_GEAR: begin
          gear_seen = 1'b1;
          park_on   = r.park;
        end
        FUNC_ESTOP: estop_on = r.estop;
        FUNC_DRIVE: begin
          if (!gear_seen) begin
            n_ignored++;
          end else begin
            res.taken = 1'b1;
            v   = r.speed;
            lim = vel_limit;
            if (v > lim) begin
              v = lim;
              res.clamped = 1'b1;
              n_clamped++;
            end
            if (park_on || estop_on) begin
              left_held  = '0;
              right_held = '0;
              n_stopped++;
            end else begin
              base  = (wheel_base == 0) ? 1 : wheel_base;
              rad   = (wheel_radius == 0) ? 1 : wheel_radius;
              tread = wheel_tread;
              off = round_div(v * (tan_q16(r.angle) * tread), 2 * base);
              mid = v * 65536;
              left_held  = wheel_rpm(mid - off, rad);
              right_held = wheel_rpm(mid + off, rad);
              n_computed++;
              if (left_held == 16'sh7fff || left_held == -16'sh8000 ||
                  right_held == 16'sh7fff || right_held == -16'sh8000)
                n_saturated++;
            end
          end
        end
        default: ;
      endcase
      res.left   = left_held;
      res.right  = right_held;
      res.enable = (left_held != 0) || (right_held != 0);
      expected_q.push_back(res);
    endfunction

    function void compare(string field, longint want_v, longint got_v);
      if (want_v != got_v) begin
        n_errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want_v, got_v);
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      wheel_result_t got, want;
      got = data[RESULT_W-1:0];
      n_results++;
      if (expected_q.size() == 0) begin
        n_errors++;
        $display("%0t: result %h with no request pending, expected none actual %h",
                 $time, data, data);
        return;
      end
      want = expected_q.pop_front();
      compare("command_taken", want.taken, got.taken);
      compare("left_rpm", want.left, got.left);
      compare("right_rpm", want.right, got.right);
      compare("drive_enable", want.enable, got.enable);
      compare("speed_was_clamped", want.clamped, got.clamped);
      compare("tdata pad bits", 0, data[OUT_DATA_W-1:RESULT_W]);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [FUNC_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  wheel_rpm_scoreboard sb = new();
  int burst_left = 0;
  int n_settings = 1;

  ackermann_to_wheel_rpm_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("timeout: block stopped making progress");
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Result side: random ready pattern, plus long hold-offs so the block backs up.
  initial begin : receiver
    int run;
    int pick;
    int next_hold;
    next_hold  = 250;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (sb.n_results >= next_hold) begin
        next_hold += 550;
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
      end else begin
        pick = $urandom_range(9);
        if (pick < 6) begin
          out_tready <= 1'b1;
          run = $urandom_range(1, 30);
        end else if (pick < 9) begin
          out_tready <= 1'b0;
          run = $urandom_range(1, 8);
        end else begin
          out_tready <= 1'b1;
          run = 300;
        end
        repeat (run) @(negedge clk);
      end
    end
  end

  function automatic request_t req(func_t f, int speed, int angle, bit park, bit estop);
    request_t r;
    r.func  = f;
    r.speed = 16'(speed);
    r.angle = 16'(angle);
    r.park  = park;
    r.estop = estop;
    return r;
  endfunction

  function automatic logic signed [15:0] pick_speed();
    int lim, s;
    lim = sb.vel_limit;
    case ($urandom_range(3))
      0: s = $urandom_range(0, 65535);
      1: s = $urandom_range(0, 2 * lim) - lim;
      2: begin
        s = lim + $urandom_range(0, 6) - 3;
        if (s > 32767) s = 32767;
      end
      default: begin
        case ($urandom_range(3))
          0: s = -32768;
          1: s = 32767;
          2: s = 0;
          default: s = -1;
        endcase
      end
    endcase
    return 16'(s);
  endfunction

  function automatic logic signed [15:0] pick_angle();
    int s;
    case ($urandom_range(7))
      0: s = $urandom_range(0, 65535);
      1: begin
        // straddle the saturation point near a quarter turn
        s = 25733 + $urandom_range(0, 5);
        if ($urandom_range(1)) s = -s;
      end
      default: s = $urandom_range(0, 51470) - 25735;
    endcase
    return 16'(s);
  endfunction

  function automatic request_t rand_request();
    request_t r;
    int pick;
    r.speed = 16'($urandom);
    r.angle = 16'($urandom);
    r.park  = $urandom_range(1);
    r.estop = $urandom_range(1);
    pick = $urandom_range(99);
    if (pick < 74) begin
      r.func  = FUNC_DRIVE;
      r.speed = pick_speed();
      r.angle = pick_angle();
    end else if (pick < 86) begin
      r.func = FUNC_GEAR;
      r.park = ($urandom_range(3) == 0);
    end else if (pick < 97) begin
      r.func  = FUNC_ESTOP;
      r.estop = ($urandom_range(3) == 0);
    end else begin
      r.func = FUNC_UNUSED;
    end
    return r;
  endfunction

  task automatic send_request(request_t r);
    in_tvalid <= 1'b1;
    in_tuser  <= r.func;
    in_tdata  <= {{(IN_DATA_W - 34){1'b0}}, r.estop, r.park, r.angle, r.speed};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  // Drop valid and hold until every expected result is back.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      case ($urandom_range(9))
        0, 1, 2: gap = 0;
        9:       gap = $urandom_range(100, 260);
        default: gap = $urandom_range(1, 20);
      endcase
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end else if ($urandom_range(299) == 0) begin
      drain();
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic apply_setting(logic [14:0] lim, logic [14:0] base, logic [14:0] tread,
                               logic [14:0] radius);
    drain();
    write_reg(CFG_VEL_LIMIT, lim);
    write_reg(CFG_BASE, base);
    write_reg(CFG_TREAD, tread);
    write_reg(CFG_RADIUS, radius);
    cfg_we <= 1'b0;
    @(negedge clk);
    n_settings++;
  endtask

  task automatic random_requests(int count);
    repeat (count) begin
      send_request(rand_request());
      pace();
    end
  endtask

  initial begin : stimulus
    request_t directed[$];
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Register defaults: commands before any gear, stop flags, field extremes.
    directed.push_back(req(FUNC_DRIVE, 500, 0, 0, 0));
    directed.push_back(req(FUNC_UNUSED, -1, -1, 1, 1));
    directed.push_back(req(FUNC_ESTOP, 0, 0, 0, 1));
    directed.push_back(req(FUNC_DRIVE, 32767, 3000, 0, 0));
    directed.push_back(req(FUNC_GEAR, 0, 0, 0, 0));
    directed.push_back(req(FUNC_DRIVE, 500, 4000, 0, 0));
    directed.push_back(req(FUNC_ESTOP, 0, 0, 0, 0));
    directed.push_back(req(FUNC_DRIVE, 0, 0, 0, 0));
    directed.push_back(req(FUNC_DRIVE, 32767, 0, 1, 1));
    directed.push_back(req(FUNC_DRIVE, -32768, 25735, 0, 0));
    directed.push_back(req(FUNC_DRIVE, 830, -25735, 0, 0));
    directed.push_back(req(FUNC_DRIVE, 831, 32767, 0, 0));
    directed.push_back(req(FUNC_DRIVE, 400, -32768, 0, 0));
    directed.push_back(req(FUNC_DRIVE, -1, 1, 0, 0));
    directed.push_back(req(FUNC_DRIVE, 300, 12868, 0, 0));
    directed.push_back(req(FUNC_GEAR, 0, 0, 1, 0));
    directed.push_back(req(FUNC_DRIVE, 500, 5000, 0, 0));
    directed.push_back(req(FUNC_UNUSED, 100, 100, 0, 0));
    directed.push_back(req(FUNC_GEAR, -32768, 32767, 0, 1));
    directed.push_back(req(FUNC_DRIVE, 200, -8000, 0, 0));
    directed.push_back(req(FUNC_ESTOP, 0, 0, 1, 1));
    directed.push_back(req(FUNC_DRIVE, -300, 100, 0, 0));
    directed.push_back(req(FUNC_ESTOP, 0, 0, 0, 0));
    directed.push_back(req(FUNC_DRIVE, 829, 25736, 0, 0));
    directed.push_back(req(FUNC_DRIVE, -830, -25736, 0, 0));
    foreach (directed[i]) begin
      send_request(directed[i]);
      pace();
    end
    random_requests(136);

    apply_setting(15'd32767, 15'd8191, 15'd8191, 15'd2047);
    random_requests(136);
    // zero base and radius act as one; zero tread removes the turn
    apply_setting(15'd0, 15'd0, 15'd0, 15'd0);
    random_requests(136);
    apply_setting(15'd1000, 15'd1, 15'd8191, 15'd1);
    random_requests(136);
    repeat (4) begin
      apply_setting(15'($urandom_range(0, 32767)),
                    15'(($urandom_range(0, 3) << 13) | $urandom_range(1, 8191)),
                    15'(($urandom_range(0, 3) << 13) | $urandom_range(1, 8191)),
                    15'(($urandom_range(0, 15) << 11) | $urandom_range(10, 2047)));
      random_requests(136);
    end
    // defaults again, with junk above the width of base, tread and radius
    apply_setting(15'd830, 15'd1000 | (15'd3 << 13), 15'd500 | (15'd1 << 13),
                  15'd100 | (15'd5 << 11));
    random_requests(136);

    drain();
    repeat (20) @(negedge clk);
    $display("%0d requests, %0d register settings: %0d computed, %0d stopped, %0d ignored",
             sb.n_requests, n_settings, sb.n_computed, sb.n_stopped, sb.n_ignored);
    $display("%0d clamped, %0d at rpm limit, %0d results checked, %0d mismatches",
             sb.n_clamped, sb.n_saturated, sb.n_results, sb.n_errors);
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
